### rtl/core/relay_lock_timer_led_driver_core_assert.svh
// Assertion macros used by the relay lock driver checker
`ifndef RELAY_LOCK_TIMER_LED_DRIVER_CORE_ASSERT_SVH
`define RELAY_LOCK_TIMER_LED_DRIVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define RLTLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define RLTLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rltld_pkg.sv
// Types and constants for the relay lock timer and LED driver
package rltld_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_OPEN       = 3'd1,
    FUNC_CLOSE      = 3'd2,
    FUNC_CLOSE_ALL  = 3'd3,
    FUNC_SET_HINT   = 3'd4,
    FUNC_CLEAR_HINT = 3'd5
  } func_e;

  localparam int unsigned FuncW     = 3;
  localparam int unsigned LockIdW   = 4;
  localparam int unsigned MaxLocks  = 4;
  localparam int unsigned DriveW    = 8;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam int unsigned NumLocksDef   = 4;
  localparam int unsigned CountWidthDef = 32;

  localparam logic [CfgIdxW-1:0] CFG_OPEN_DURATION = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FORCE_OFF     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_HALF    = 2'd2;

  localparam logic [CfgW-1:0] OpenDurationRst = 32'd3000;
  localparam logic [CfgW-1:0] ForceOffRst     = 32'd10000;
  localparam logic [CfgW-1:0] BlinkHalfRst    = 32'd500;

  localparam logic [2:0] RelayPos [MaxLocks] = '{3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [2:0] LedPos   [MaxLocks] = '{3'd3, 3'd2, 3'd1, 3'd0};

endpackage

### rtl/core/relay_lock_timer_led_driver_core.sv
// Relay lock timer and LED driver: command decode, lock timers, hint blink
// An input beat passes through the input register and then the result register.
// Throughput: one beat per cycle while the result is not stalled; state updates in one pass of logic per beat.
// A stalled result holds; the input register takes the next beat only while it is empty.
// Reset clears all locks, timers, hints and blink state and loads default limits.
module relay_lock_timer_led_driver_core #(
  parameter int unsigned NUM_LOCKS   = rltld_pkg::NumLocksDef,
  parameter int unsigned COUNT_WIDTH = rltld_pkg::CountWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rltld_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rltld_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rltld_pkg::FuncW-1:0]         func_i,
  input  logic [rltld_pkg::LockIdW-1:0]       lock_id_i,
  input  logic [rltld_pkg::MaxLocks-1:0]      hint_mask_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rltld_pkg::DriveW-1:0]        drive_byte_o,
  output logic [rltld_pkg::MaxLocks-1:0]      open_mask_o,
  output logic                                hint_active_o,
  output logic                                accepted_o
);

  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [rltld_pkg::CfgW-1:0] open_dur_q, force_off_q, blink_half_q;

  logic                               in_valid_q, in_valid_d;
  logic [rltld_pkg::FuncW-1:0]        func_q;
  logic [rltld_pkg::LockIdW-1:0]      lock_id_q;
  logic [rltld_pkg::MaxLocks-1:0]     hint_mask_q;

  logic [NUM_LOCKS-1:0]   lock_on_q, lock_on_d;
  logic [COUNT_WIDTH-1:0] hold_q [NUM_LOCKS];
  logic [COUNT_WIDTH-1:0] hold_d [NUM_LOCKS];
  logic [COUNT_WIDTH-1:0] act_q  [NUM_LOCKS];
  logic [COUNT_WIDTH-1:0] act_d  [NUM_LOCKS];
  logic [NUM_LOCKS-1:0]   hint_q, hint_d;
  logic                   phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] blink_q, blink_d;

  logic                               out_valid_q, out_valid_d;
  logic [rltld_pkg::DriveW-1:0]       drive_q, drive_d;
  logic [rltld_pkg::MaxLocks-1:0]     open_q, open_d;
  logic                               hint_act_q, hint_act_d;
  logic                               ok_q, ok_d;

  logic fire;
  logic in_take;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      in_valid_d  = 1'b0;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end
  end

  always_comb begin
    logic                   id_ok;
    logic [COUNT_WIDTH-1:0] a_inc, h_inc, b_inc;
    lock_on_d = lock_on_q;
    hold_d    = hold_q;
    act_d     = act_q;
    hint_d    = hint_q;
    phase_d   = phase_q;
    blink_d   = blink_q;
    a_inc     = '0;
    h_inc     = '0;
    id_ok     = lock_id_q < rltld_pkg::LockIdW'(NUM_LOCKS);
    ok_d      = 1'b1;
    b_inc     = (blink_q == CntMax) ? blink_q : blink_q + CntOne;
    case (rltld_pkg::func_e'(func_q))
      rltld_pkg::FUNC_TICK: begin
        for (int i = 0; i < NUM_LOCKS; i++) begin
          a_inc = (act_q[i] == CntMax) ? act_q[i] : act_q[i] + CntOne;
          h_inc = (hold_q[i] == CntMax) ? hold_q[i] : hold_q[i] + CntOne;
          if (lock_on_q[i]) begin
            if (32'(a_inc) >= force_off_q || 32'(h_inc) >= open_dur_q) begin
              lock_on_d[i] = 1'b0;
              act_d[i]     = '0;
              hold_d[i]    = '0;
            end else begin
              act_d[i]  = a_inc;
              hold_d[i] = h_inc;
            end
          end
        end
        if (|hint_q && 32'(b_inc) >= blink_half_q) begin
          blink_d = '0;
          phase_d = !phase_q;
        end else begin
          blink_d = b_inc;
        end
      end
      rltld_pkg::FUNC_OPEN: begin
        ok_d = id_ok;
        for (int i = 0; i < NUM_LOCKS; i++) begin
          if (lock_id_q == rltld_pkg::LockIdW'(i)) begin
            hold_d[i] = '0;
            if (!lock_on_q[i]) begin
              lock_on_d[i] = 1'b1;
              act_d[i]     = '0;
            end
          end
        end
      end
      rltld_pkg::FUNC_CLOSE: begin
        ok_d = id_ok;
        for (int i = 0; i < NUM_LOCKS; i++) begin
          if (lock_id_q == rltld_pkg::LockIdW'(i)) begin
            lock_on_d[i] = 1'b0;
            hold_d[i]    = '0;
            act_d[i]     = '0;
          end
        end
      end
      rltld_pkg::FUNC_CLOSE_ALL: begin
        lock_on_d = '0;
        for (int i = 0; i < NUM_LOCKS; i++) begin
          hold_d[i] = '0;
          act_d[i]  = '0;
        end
      end
      rltld_pkg::FUNC_SET_HINT: begin
        hint_d  = hint_mask_q[NUM_LOCKS-1:0];
        phase_d = 1'b1;
        blink_d = '0;
      end
      rltld_pkg::FUNC_CLEAR_HINT: begin
        hint_d  = '0;
        phase_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    drive_d = '0;
    for (int i = 0; i < NUM_LOCKS; i++) begin
      if (lock_on_d[i]) begin
        drive_d[rltld_pkg::RelayPos[i]] = 1'b1;
        drive_d[rltld_pkg::LedPos[i]]   = 1'b1;
      end else if (hint_d[i] && phase_d) begin
        drive_d[rltld_pkg::LedPos[i]] = 1'b1;
      end
    end
    open_d     = rltld_pkg::MaxLocks'(lock_on_d);
    hint_act_d = |hint_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_dur_q  <= rltld_pkg::OpenDurationRst;
      force_off_q <= rltld_pkg::ForceOffRst;
      blink_half_q <= rltld_pkg::BlinkHalfRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rltld_pkg::CFG_OPEN_DURATION: open_dur_q   <= cfg_data_i;
        rltld_pkg::CFG_FORCE_OFF:     force_off_q  <= cfg_data_i;
        rltld_pkg::CFG_BLINK_HALF:    blink_half_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lock_on_q   <= '0;
      hint_q      <= '0;
      phase_q     <= 1'b0;
      blink_q     <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        hold_q[i] <= '0;
        act_q[i]  <= '0;
      end
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        lock_on_q <= lock_on_d;
        hint_q    <= hint_d;
        phase_q   <= phase_d;
        blink_q   <= blink_d;
        hold_q    <= hold_d;
        act_q     <= act_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q      <= func_i;
      lock_id_q   <= lock_id_i;
      hint_mask_q <= hint_mask_i;
    end
    if (fire) begin
      drive_q    <= drive_d;
      open_q     <= open_d;
      hint_act_q <= hint_act_d;
      ok_q       <= ok_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_byte_o  = drive_q;
  assign open_mask_o   = open_q;
  assign hint_active_o = hint_act_q;
  assign accepted_o    = ok_q;

endmodule

### rtl/core/rltld_checker.sv
// Port-level checker for the relay lock driver, bound to the core module
`include "relay_lock_timer_led_driver_core_assert.svh"

module rltld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] drive_byte_o,
  input logic [3:0] open_mask_o,
  input logic       hint_active_o,
  input logic       accepted_o
);

  `RLTLD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(drive_byte_o) && $stable(open_mask_o) &&
    $stable(hint_active_o) && $stable(accepted_o), "result beat changed while stalled")

  `RLTLD_ASSERT_NOW(a_relay_match, out_valid_o, drive_byte_o[7:4] == open_mask_o,
    "relay bits differ from open mask")

  `RLTLD_ASSERT_NOW(a_open_led_on, out_valid_o,
    (!open_mask_o[0] || drive_byte_o[3]) && (!open_mask_o[1] || drive_byte_o[2]) &&
    (!open_mask_o[2] || drive_byte_o[1]) && (!open_mask_o[3] || drive_byte_o[0]),
    "open lock with LED off")

  `RLTLD_ASSERT_NOW(a_no_hint_led, out_valid_o && !hint_active_o,
    drive_byte_o[3:0] == {open_mask_o[0], open_mask_o[1], open_mask_o[2], open_mask_o[3]},
    "LED lit on closed lock without hint")

endmodule

bind relay_lock_timer_led_driver_core rltld_checker u_rltld_checker (.*);
